// File: hw/rtl/delimited_field_select_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delimited field select block
// Shorthand for the clocked implication checks used by its checker.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FIELD_SELECT_ASSERT_SVH
`define DELIMITED_FIELD_SELECT_ASSERT_SVH

// Next-cycle implication, switched off while reset is high.
`define DFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication that also holds across reset.
`define DFS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// File: hw/rtl/dfs_pkg.sv
// ----------------------------------------------------------------------------
// Delimited field select package
// Shared widths, character codes, status codes, register indexes and types.
// ----------------------------------------------------------------------------
package dfs_pkg;

   localparam int CHAR_W        = 8;
   localparam int STATUS_W      = 2;
   localparam int FIELD_INDEX_W = 16;
   localparam int DELIM_LEN_W   = 3;
   localparam int DELIM_BYTES_W = 32;
   localparam int CAPACITY_W    = 17;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_INDEX  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_LEN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELIM_BYTES  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_CAPACITY = 2'd3;

   typedef enum logic [1:0] {
      PH_SKIPPING,
      PH_EMITTING,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [FIELD_INDEX_W-1:0] field_index;
      logic [DELIM_LEN_W-1:0]   delim_len;
      logic [DELIM_BYTES_W-1:0] delim_bytes;
      logic [CAPACITY_W-1:0]    out_capacity;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      field_index:  16'd0,
      delim_len:    3'd1,
      delim_bytes:  32'd44,
      out_capacity: 17'd256
   };

   typedef struct packed {
      logic                valid;
      logic [CHAR_W-1:0]   field_byte;
      logic                end_mark;
      logic [STATUS_W-1:0] end_status;
   } res_type;

endpackage

// File: hw/rtl/dfs_csr.sv
// ----------------------------------------------------------------------------
// Delimited field select configuration registers
// Holds field index, delimiter length, delimiter bytes and output capacity.
// ----------------------------------------------------------------------------
module dfs_csr
   import dfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FIELD_INDEX:  cfg_in.field_index  = csr_wdata[FIELD_INDEX_W-1:0];
            CSR_DELIM_LEN:    cfg_in.delim_len    = csr_wdata[DELIM_LEN_W-1:0];
            CSR_DELIM_BYTES:  cfg_in.delim_bytes  = csr_wdata[DELIM_BYTES_W-1:0];
            CSR_OUT_CAPACITY: cfg_in.out_capacity = csr_wdata[CAPACITY_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/dfs_core.sv
// ----------------------------------------------------------------------------
// Delimited field select window engine
// Keeps the look-ahead window and line state and performs one window
// examination per advancing cycle, giving at most one result.
// ----------------------------------------------------------------------------
module dfs_core
   import dfs_pkg::*;
#(
   parameter int MAX_DELIM_BYTES = 4,
   parameter int INDEX_BITS      = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [CHAR_W-1:0] in_char,
   input  logic              in_fresh,
   input  cfg_type           cfg,
   output res_type           res,
   output logic              item_done
);

   localparam int FW = $clog2(MAX_DELIM_BYTES + 1);

   typedef enum logic [3:0] {
      ACT_IGNORE,
      ACT_APPEND,
      ACT_LINE_END,
      ACT_FIELD_END,
      ACT_FULL,
      ACT_CROSS,
      ACT_EMIT,
      ACT_DROP,
      ACT_REARM
   } action_type;

   logic [CHAR_W-1:0]     win_ff [MAX_DELIM_BYTES];
   logic [CHAR_W-1:0]     win_in [MAX_DELIM_BYTES];
   logic [FW-1:0]         fill_ff;
   logic [FW-1:0]         fill_in;
   logic [INDEX_BITS-1:0] crossed_ff;
   logic [INDEX_BITS-1:0] crossed_in;
   phase_type             phase_ff;
   phase_type             phase_in;
   logic [CAPACITY_W-1:0] emitted_ff;
   logic [CAPACITY_W-1:0] emitted_in;

   logic [CHAR_W-1:0]     wwin  [MAX_DELIM_BYTES];
   logic [CHAR_W-1:0]     sh1   [MAX_DELIM_BYTES];
   logic [CHAR_W-1:0]     shd   [MAX_DELIM_BYTES];
   logic [FW-1:0]         wfill;
   logic [FW-1:0]         dlen;
   logic [INDEX_BITS-1:0] eff_index;
   logic [CAPACITY_W-1:0] room;
   logic                  is_nul;
   logic                  appending;
   logic                  head_nl;
   logic                  dmatch;
   logic                  full;
   phase_type             eph;
   action_type            act;
   action_type            exam_act;

   assign is_nul    = (in_char == CHAR_NUL);
   assign appending = !is_nul && in_fresh;
   assign eff_index = INDEX_BITS'(cfg.field_index);
   assign room      = (cfg.out_capacity == '0) ? '0 : cfg.out_capacity - CAPACITY_W'(1);
   assign full      = (emitted_ff >= room);
   assign wfill     = appending ? fill_ff + FW'(1) : fill_ff;
   assign head_nl   = (wwin[0] == CHAR_NEWLINE);

   always_comb begin
      if (cfg.delim_len == '0) begin
         dlen = FW'(1);
      end else if (int'(cfg.delim_len) > MAX_DELIM_BYTES) begin
         dlen = FW'(MAX_DELIM_BYTES);
      end else begin
         dlen = FW'(cfg.delim_len);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
         wwin[i] = win_ff[i];
         if (appending && fill_ff == FW'(i)) begin
            wwin[i] = in_char;
         end
      end
   end

   always_comb begin
      dmatch = (wfill >= dlen);
      for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
         if (FW'(i) < dlen && wwin[i] != CHAR_W'(cfg.delim_bytes >> (CHAR_W * i))) begin
            dmatch = 1'b0;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
         sh1[i] = (i + 1 < MAX_DELIM_BYTES) ? wwin[(i + 1) % MAX_DELIM_BYTES] : wwin[i];
         shd[i] = wwin[i];
         for (int j = 1; j < MAX_DELIM_BYTES; j++) begin
            if (i + j < MAX_DELIM_BYTES && dlen == FW'(j)) begin
               shd[i] = wwin[(i + j) % MAX_DELIM_BYTES];
            end
         end
      end
   end

   assign eph = (phase_ff == PH_SKIPPING && crossed_ff >= eff_index) ? PH_EMITTING : phase_ff;

   always_comb begin
      priority if (head_nl) begin
         exam_act = ACT_LINE_END;
      end else if (dmatch) begin
         exam_act = (eph == PH_EMITTING) ? ACT_FIELD_END : ACT_CROSS;
      end else if (eph == PH_EMITTING) begin
         exam_act = full ? ACT_FULL : ACT_EMIT;
      end else begin
         exam_act = ACT_DROP;
      end
   end

   always_comb begin
      if (!is_nul) begin
         priority if (phase_ff == PH_DONE) begin
            act = ACT_IGNORE;
         end else if (wfill < dlen) begin
            act = ACT_APPEND;
         end else begin
            act = exam_act;
         end
      end else begin
         if (phase_ff != PH_DONE && fill_ff != '0) begin
            act = exam_act;
         end else begin
            act = ACT_REARM;
         end
      end
   end

   // Next state.
   always_comb begin
      win_in     = win_ff;
      fill_in    = fill_ff;
      crossed_in = crossed_ff;
      phase_in   = phase_ff;
      emitted_in = emitted_ff;
      unique case (act)
         ACT_IGNORE: begin
         end
         ACT_APPEND: begin
            win_in  = wwin;
            fill_in = wfill;
         end
         ACT_LINE_END, ACT_FIELD_END, ACT_FULL: begin
            fill_in  = '0;
            phase_in = PH_DONE;
         end
         ACT_CROSS: begin
            win_in     = shd;
            fill_in    = wfill - dlen;
            crossed_in = crossed_ff + INDEX_BITS'(1);
            phase_in   = eph;
         end
         ACT_EMIT: begin
            win_in     = sh1;
            fill_in    = wfill - FW'(1);
            emitted_in = emitted_ff + CAPACITY_W'(1);
            phase_in   = eph;
         end
         ACT_DROP: begin
            win_in   = sh1;
            fill_in  = wfill - FW'(1);
            phase_in = eph;
         end
         ACT_REARM: begin
            fill_in    = '0;
            crossed_in = '0;
            emitted_in = '0;
            phase_in   = PH_SKIPPING;
         end
         default: begin
         end
      endcase
   end

   // Result and item completion.
   always_comb begin
      res            = '0;
      res.end_status = ST_OK;
      item_done      = 1'b1;
      unique case (act)
         ACT_IGNORE, ACT_APPEND: begin
         end
         ACT_REARM: begin
            if (phase_ff != PH_DONE) begin
               res.valid    = 1'b1;
               res.end_mark = 1'b1;
               res.end_status =
                  (phase_ff == PH_SKIPPING && crossed_ff < eff_index) ? ST_FEW : ST_OK;
            end
         end
         default: begin
            item_done = !is_nul && (phase_in == PH_DONE || fill_in < dlen);
            unique case (act)
               ACT_LINE_END: begin
                  res.valid      = 1'b1;
                  res.end_mark   = 1'b1;
                  res.end_status = (eph == PH_SKIPPING) ? ST_FEW : ST_OK;
               end
               ACT_FIELD_END: begin
                  res.valid    = 1'b1;
                  res.end_mark = 1'b1;
               end
               ACT_FULL: begin
                  res.valid      = 1'b1;
                  res.end_mark   = 1'b1;
                  res.end_status = ST_FULL;
               end
               ACT_EMIT: begin
                  res.valid      = 1'b1;
                  res.field_byte = wwin[0];
               end
               default: begin
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         crossed_ff <= '0;
         phase_ff   <= PH_SKIPPING;
         emitted_ff <= '0;
      end else if (advance) begin
         fill_ff    <= fill_in;
         crossed_ff <= crossed_in;
         phase_ff   <= phase_in;
         emitted_ff <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         win_ff <= win_in;
      end
   end

endmodule

// File: hw/rtl/delimited_field_select.sv
// A byte is registered on transfer; the result it causes is registered onto rsp.
// Throughput: one byte per cycle while rsp is not stalled, set by the single window
// examination per cycle. Each further examination of one byte holds the input: a zero
// byte drains the window, and a delimiter shortened mid-line drains it below its length.
// Reset is synchronous: it clears line state and handshakes and loads register defaults.
// ----------------------------------------------------------------------------
// Delimited field select
// Streams a zero-terminated text line and returns the bytes of one
// delimiter-separated field followed by an end mark with status.
// ----------------------------------------------------------------------------
module delimited_field_select
   import dfs_pkg::*;
#(
   parameter int MAX_DELIM_BYTES = 4,
   parameter int INDEX_BITS      = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_char_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_W-1:0]     rsp_field_byte,
   output logic                  rsp_end_mark,
   output logic [STATUS_W-1:0]   rsp_end_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type           cfg;
   res_type           res;
   logic              item_done;
   logic              advance;
   logic              consumed;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic              in_fresh_ff;
   logic              in_fresh_in;
   logic [CHAR_W-1:0] in_char_ff;
   res_type           out_ff;
   res_type           out_in;

   dfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dfs_core #(
      .MAX_DELIM_BYTES (MAX_DELIM_BYTES),
      .INDEX_BITS      (INDEX_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_char   (in_char_ff),
      .in_fresh  (in_fresh_ff),
      .cfg       (cfg),
      .res       (res),
      .item_done (item_done)
   );

   assign advance   = in_valid_ff && (!out_ff.valid || !rsp_stall);
   assign consumed  = advance && item_done;
   assign req_stall = in_valid_ff && !consumed;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_fresh_in = in_fresh_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_fresh_in = 1'b1;
      end else if (consumed) begin
         in_valid_in = 1'b0;
      end else if (advance) begin
         in_fresh_in = 1'b0;
      end
   end

   always_comb begin
      out_in = out_ff;
      if (advance && res.valid) begin
         out_in = res;
      end else if (!rsp_stall) begin
         out_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         in_fresh_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         in_fresh_ff <= in_fresh_in;
         out_ff.valid <= out_in.valid;
      end
      out_ff.field_byte <= out_in.field_byte;
      out_ff.end_mark   <= out_in.end_mark;
      out_ff.end_status <= out_in.end_status;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_in;
      end
   end

   assign rsp_valid      = out_ff.valid;
   assign rsp_field_byte = out_ff.field_byte;
   assign rsp_end_mark   = out_ff.end_mark;
   assign rsp_end_status = out_ff.end_status;

endmodule

// File: hw/rtl/dfs_checker.sv
// ----------------------------------------------------------------------------
// Delimited field select port checker
// Watches the top level ports for reset, input flow and result hold behavior.
// ----------------------------------------------------------------------------
`include "delimited_field_select_assert.svh"

module dfs_checker
   import dfs_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [CHAR_W-1:0]   rsp_field_byte,
   input logic                rsp_end_mark,
   input logic [STATUS_W-1:0] rsp_end_status
);

   // A stalled result stays offered with the same contents.
   `DFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_field_byte) && $stable(rsp_end_mark) && $stable(rsp_end_status))

   // Reset leaves no result pending and the input open.
   `DFS_ASSERT_NEXT_ALWAYS(a_reset_clean, clock, reset, !rsp_valid && !req_stall)

   // With nothing held and nothing transferred, the input stays open.
   `DFS_ASSERT_NEXT(a_idle_open, clock, reset, !req_stall && !req_valid, !req_stall)

endmodule

bind delimited_field_select dfs_checker u_checker (.*);

// File: tb/delimited_field_select_tb.sv
// ----------------------------------------------------------------------------
// Delimited field select testbench
// Streams zero-terminated text lines into the block under several register
// settings and checks every returned field byte and end mark against a
// cycle-free model of the field extraction, with random gaps on both sides.
// ----------------------------------------------------------------------------
module delimited_field_select_tb;
   import dfs_pkg::*;

   localparam int DELIM_SLOTS   = 4;
   localparam int RANDOM_ITEMS  = 120;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic [CHAR_W-1:0] PUNCT [6] = '{8'h2C, 8'h3B, 8'h7C, 8'h3A, 8'h09, 8'h23};

   class field_select_scoreboard;
      cfg_type           cfg;
      logic [CHAR_W-1:0] win [DELIM_SLOTS];
      int unsigned       fill;
      int unsigned       crossed;
      int unsigned       emitted;
      phase_type         line_phase;
      res_type           due_q [$];
      int unsigned       mismatches;

      function new();
         cfg        = CFG_RESET;
         fill       = 0;
         crossed    = 0;
         emitted    = 0;
         line_phase = PH_SKIPPING;
         mismatches = 0;
      endfunction

      function void configure(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FIELD_INDEX:  cfg.field_index  = data[FIELD_INDEX_W-1:0];
            CSR_DELIM_LEN:    cfg.delim_len    = data[DELIM_LEN_W-1:0];
            CSR_DELIM_BYTES:  cfg.delim_bytes  = data[DELIM_BYTES_W-1:0];
            CSR_OUT_CAPACITY: cfg.out_capacity = data[CAPACITY_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned delim_span();
         int unsigned d;
         d = 32'(cfg.delim_len);
         if (d < 1) d = 1;
         if (d > DELIM_SLOTS) d = DELIM_SLOTS;
         return d;
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction

      function void expect_result(logic [CHAR_W-1:0] b, logic m, logic [STATUS_W-1:0] s);
         res_type r;
         r.valid      = 1'b1;
         r.field_byte = b;
         r.end_mark   = m;
         r.end_status = s;
         due_q.push_back(r);
      endfunction

      function void close_line(logic [STATUS_W-1:0] st);
         expect_result(CHAR_NUL, 1'b1, st);
         line_phase = PH_DONE;
         fill       = 0;
      endfunction

      function logic [STATUS_W-1:0] line_status();
         return (line_phase == PH_SKIPPING && crossed < 32'(cfg.field_index)) ? ST_FEW : ST_OK;
      endfunction

      function void drop_head(int unsigned k);
         if (k >= fill) begin
            fill = 0;
            return;
         end
         for (int unsigned i = 0; i + k < fill; i++) win[i] = win[i + k];
         fill -= k;
      endfunction

      function void examine();
         int unsigned       d;
         int unsigned       room;
         bit                hit;
         logic [CHAR_W-1:0] head;
         d = delim_span();
         if (fill == 0) return;
         if (line_phase == PH_SKIPPING && crossed >= 32'(cfg.field_index)) begin
            line_phase = PH_EMITTING;
         end
         head = win[0];
         if (head == CHAR_NEWLINE) begin
            close_line(line_status());
            return;
         end
         hit = (fill >= d);
         for (int unsigned i = 0; i < d; i++) begin
            if (hit && win[i] != cfg.delim_bytes[8*i +: 8]) hit = 1'b0;
         end
         if (hit) begin
            if (line_phase == PH_EMITTING) begin
               close_line(ST_OK);
            end else begin
               crossed++;
               drop_head(d);
            end
            return;
         end
         if (line_phase == PH_EMITTING) begin
            room = 32'(cfg.out_capacity);
            if (room > 0) room--;
            if (emitted >= room) begin
               close_line(ST_FULL);
               return;
            end
            expect_result(head, 1'b0, ST_OK);
            emitted++;
         end
         drop_head(1);
      endfunction

      // Returns whether the byte took part in the line rather than being ignored.
      function bit note_byte(logic [CHAR_W-1:0] c);
         if (c != CHAR_NUL) begin
            if (line_phase == PH_DONE) return 1'b0;
            if (fill < DELIM_SLOTS) begin
               win[fill] = c;
               fill++;
            end
            for (int unsigned n = 0; n < DELIM_SLOTS; n++) begin
               if (line_phase == PH_DONE || fill < delim_span()) break;
               examine();
            end
            return 1'b1;
         end
         while (line_phase != PH_DONE && fill > 0) examine();
         if (line_phase != PH_DONE) close_line(line_status());
         fill       = 0;
         crossed    = 0;
         emitted    = 0;
         line_phase = PH_SKIPPING;
         return 1'b1;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_result(logic [CHAR_W-1:0] b, logic m, logic [STATUS_W-1:0] s);
         res_type want;
         if (due_q.size() == 0) begin
            flag($sformatf("unexpected transfer byte %02h mark %0b status %0d", b, m, s));
            return;
         end
         want = due_q.pop_front();
         if (want.field_byte !== b || want.end_mark !== m || want.end_status !== s) begin
            flag($sformatf("expected byte %02h mark %0b status %0d, got byte %02h mark %0b status %0d",
                           want.field_byte, want.end_mark, want.end_status, b, m, s));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_char_in;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [CHAR_W-1:0]     rsp_field_byte;
   logic                  rsp_end_mark;
   logic [STATUS_W-1:0]   rsp_end_status;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   field_select_scoreboard board = new();

   bit          tx_idle = 1'b1;
   bit          rx_idle = 1'b1;
   bit          hold_long = 1'b0;
   int unsigned live_items = 0;
   int unsigned cycle_count = 0;

   delimited_field_select i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_field_byte (rsp_field_byte),
      .rsp_end_mark   (rsp_end_mark),
      .rsp_end_status (rsp_end_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         board.check_result(rsp_field_byte, rsp_end_mark, rsp_end_status);
      end
   end

   initial begin
      int unsigned wait_n;
      rsp_stall = 1'b0;
      forever begin
         if (hold_long) begin
            wait_n    = HOLD_CYCLES;
            hold_long = 1'b0;
         end else begin
            wait_n = rx_idle ? $urandom_range(0, 15) : 0;
         end
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset);
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] c);
      int unsigned gap;
      gap = tx_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (board.note_byte(c)) live_items++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.configure(idx, data);
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] fi, input logic [CSR_DATA_W-1:0] dl,
                                 input logic [CSR_DATA_W-1:0] db, input logic [CSR_DATA_W-1:0] cap);
      write_reg(CSR_FIELD_INDEX, fi);
      write_reg(CSR_DELIM_LEN, dl);
      write_reg(CSR_DELIM_BYTES, db);
      write_reg(CSR_OUT_CAPACITY, cap);
      csr_valid <= 1'b0;
   endtask

   task automatic send_line();
      int unsigned       nf;
      int unsigned       len;
      int unsigned       dl;
      int unsigned       cut;
      logic [31:0]       db;
      logic [CHAR_W-1:0] c;
      dl = board.delim_span();
      db = board.cfg.delim_bytes;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 8)) send_char(CHAR_W'($urandom_range(1, 255)));
      end else begin
         nf = $urandom_range(1, 5);
         for (int f = 0; f < nf; f++) begin
            len = $urandom_range(0, 4);
            repeat (len) begin
               case ($urandom_range(0, 15))
                  0: c = CHAR_NEWLINE;
                  1, 2, 3: c = CHAR_W'($urandom_range(1, 255));
                  default: c = 8'h61 + CHAR_W'($urandom_range(0, 25));
               endcase
               send_char(c);
            end
            if (f + 1 < nf) begin
               cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, dl - 1) : dl;
               for (int k = 0; k < cut; k++) begin
                  c = db[8*k +: 8];
                  send_char(c != CHAR_NUL ? c : CHAR_W'($urandom_range(1, 255)));
               end
            end
         end
      end
      send_char(CHAR_NUL);
   endtask

   initial begin
      int unsigned       rand_goal;
      int unsigned       phase_no;
      logic [31:0]       fi;
      logic [31:0]       db;
      logic [31:0]       cap;
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_char_in = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: the first field ends at a comma, the rest of the line is ignored.
      send_char(8'h61);
      send_char(8'hFF);
      send_text(",b");
      send_char(CHAR_NUL);

      // A newline that opens the delimiter ends the line before one field is crossed.
      settle();
      apply_settings(1, 2, 32'h0000_3B0A, 256);
      send_text("a\n;b");
      send_char(CHAR_NUL);

      // Four-byte delimiter, then the smallest buffer fills during the end-of-string flush.
      settle();
      apply_settings(1, 4, 32'h2D2D_2D2D, 2);
      send_text("ab----cde");
      send_char(CHAR_NUL);

      // The delimiter shrinks while a partial window is held, releasing several bytes at once.
      settle();
      apply_settings(0, 3, 32'h0063_6261, 32'h0001_0000);
      send_text("xy");
      settle();
      write_reg(CSR_DELIM_LEN, 1);
      csr_valid <= 1'b0;
      send_text("za");
      send_char(CHAR_NUL);

      rand_goal = live_items + RANDOM_ITEMS;
      phase_no  = 0;
      while (live_items < rand_goal) begin
         settle();
         fi = ($urandom_range(0, 5) == 0) ? 32'hFFFF : $urandom_range(0, 3);
         db = $urandom;
         if ($urandom_range(0, 3) != 0) begin
            for (int k = 0; k < 4; k++) begin
               db[8*k +: 8] = ($urandom_range(0, 3) == 0) ? CHAR_W'($urandom_range(1, 255))
                                                         : PUNCT[$urandom_range(0, 5)];
            end
         end
         case ($urandom_range(0, 4))
            0: cap = 2;
            1: cap = 32'h0001_0000;
            2: cap = 256;
            default: cap = $urandom_range(2, 6);
         endcase
         if (phase_no == 0) begin
            fi  = 0;
            cap = 32'h0001_0000;
         end
         if (phase_no == 1) fi = 32'hFFFF;
         apply_settings(fi, $urandom_range(1, 4), db, cap);
         tx_idle = (phase_no % 3 != 1) && (phase_no != 0);
         rx_idle = (phase_no % 4 != 2);
         if (phase_no == 0) hold_long = 1'b1;
         repeat ($urandom_range(1, 3)) begin
            send_line();
            if (phase_no == 1) wait_drained();
         end
         phase_no++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/dfs_pkg.sv
hw/rtl/dfs_csr.sv
hw/rtl/dfs_core.sv
hw/rtl/delimited_field_select.sv
hw/rtl/dfs_checker.sv
tb/delimited_field_select_tb.sv
